// File: sv/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Check that a condition is never seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: sv/jsu_pkg.sv
`timescale 1ns / 1ps
// Types, character constants and small decode functions for the JSON string unescaper.
// No dependencies; used by jsu_core, json_string_unescape_top and jsu_chk.
package jsu_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEAD = 3'd1,
    PH_BODY = 3'd2,
    PH_ESC  = 3'd3,
    PH_HEX  = 3'd4,
    PH_SKIP = 3'd5
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BYTE       = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_NOT_STRING = 3'd2,
    ST_UNTERM     = 3'd3,
    ST_TRUNC      = 3'd4
  } status_e;

  localparam int unsigned MaxRes = 3;

  // Characters and UTF-8 constants
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChQmark  = 8'h3F;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [15:0] Utf8Max1 = 16'h007F;
  localparam logic [15:0] Utf8Max2 = 16'h07FF;
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } res_t;

  // Up to three result items produced by one input transaction
  typedef struct packed {
    res_t [MaxRes-1:0] ent;
    logic [1:0]        cnt;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic bundle_t push(bundle_t b, logic [7:0] byte_val, status_e st,
                                   logic lst);
    bundle_t r;
    r = b;
    r.ent[b.cnt].out_byte = byte_val;
    r.ent[b.cnt].status   = st;
    r.ent[b.cnt].last     = lst;
    r.cnt = b.cnt + 2'd1;
    return r;
  endfunction

  function automatic hex_t hex_digit(logic [7:0] b);
    hex_t h;
    h = '0;
    if (b inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h37);
    end
    return h;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b inside {ChSpace, [8'h09:8'h0D]};
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

// File: sv/jsu_core.sv
`timescale 1ns / 1ps
// Decoder state and the single-pass step logic of the JSON string unescaper.
// Depends on jsu_pkg; instantiated by json_string_unescape_top.
module jsu_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             begin_req_i,
  input  logic             end_of_data_i,
  input  logic [15:0]      max_out_bytes_i,
  output jsu_pkg::bundle_t res_o
);
  import jsu_pkg::*;

  localparam logic [31:0] CntMask = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

  phase_e                phase_q, phase_d, ph_cur;
  logic [2:0]            hc_q, hc_d, hc_cur;
  logic [15:0]           hv_q, hv_d, hv_cur;
  logic [2:0]            hds_q, hds_d, hds_cur;
  logic                  hs_q, hs_d, hs_cur;
  logic [COUNT_BITS-1:0] oc_q, oc_d, oc_cur;
  logic                  se_q, se_d, se_cur;

  logic [31:0]           lim_wide;
  logic [COUNT_BITS-1:0] limit;
  hex_t                  hd;
  logic [15:0]           cp;
  logic [1:0]            cp_len;
  logic [COUNT_BITS+1:0] need;
  bundle_t               bnd;

  // Clip the configured limit to the counter range
  assign lim_wide = (32'(max_out_bytes_i) > CntMask) ? CntMask : 32'(max_out_bytes_i);
  assign limit    = lim_wide[COUNT_BITS-1:0];
  assign hd       = hex_digit(data_byte_i);

  // Apply a begin request before anything else
  always_comb begin
    ph_cur  = phase_q;
    hc_cur  = hc_q;
    hv_cur  = hv_q;
    hds_cur = hds_q;
    hs_cur  = hs_q;
    oc_cur  = oc_q;
    se_cur  = se_q;
    if (begin_req_i) begin
      ph_cur  = PH_LEAD;
      hc_cur  = '0;
      hv_cur  = '0;
      hds_cur = '0;
      hs_cur  = 1'b0;
      oc_cur  = '0;
      se_cur  = 1'b0;
    end
  end

  // Code point after this byte's hex digit, and its UTF-8 length and fit
  always_comb begin
    cp = hv_cur;
    if (!hs_cur && hd.ok) cp = {hv_cur[11:0], hd.val};
    if (cp <= Utf8Max1)      cp_len = 2'd1;
    else if (cp <= Utf8Max2) cp_len = 2'd2;
    else                     cp_len = 2'd3;
    need = {2'b00, oc_cur} + (COUNT_BITS+2)'(cp_len);
  end

  // Decode one byte or end mark
  always_comb begin
    phase_d = ph_cur;
    hc_d    = hc_cur;
    hv_d    = hv_cur;
    hds_d   = hds_cur;
    hs_d    = hs_cur;
    oc_d    = oc_cur;
    se_d    = se_cur;
    bnd     = '0;
    if (ph_cur == PH_IDLE) begin
      phase_d = PH_IDLE;
    end else if (end_of_data_i) begin
      case (ph_cur)
        PH_LEAD: bnd = push(bnd, 8'h00, ST_NOT_STRING, 1'b1);
        PH_SKIP: bnd = push(bnd, 8'h00, ST_TRUNC, 1'b1);
        PH_ESC: begin
          bnd  = push(bnd, ChBslash, ST_BYTE, 1'b0);
          oc_d = oc_cur + COUNT_BITS'(1);
          bnd  = push(bnd, 8'h00, ST_UNTERM, 1'b1);
        end
        PH_HEX: begin
          if (oc_cur < limit) begin
            bnd  = push(bnd, ChQmark, ST_BYTE, 1'b0);
            oc_d = oc_cur + COUNT_BITS'(1);
          end
          bnd = push(bnd, 8'h00, ST_UNTERM, 1'b1);
        end
        default: bnd = push(bnd, 8'h00, ST_UNTERM, 1'b1);
      endcase
      phase_d = PH_IDLE;
    end else begin
      case (ph_cur)
        PH_LEAD: begin
          if (data_byte_i == ChQuote) begin
            phase_d = PH_BODY;
          end else if (!is_space(data_byte_i)) begin
            bnd     = push(bnd, 8'h00, ST_NOT_STRING, 1'b1);
            phase_d = PH_IDLE;
          end
        end
        PH_BODY: begin
          if (data_byte_i == ChQuote) begin
            bnd     = push(bnd, 8'h00, ST_COMPLETE, 1'b1);
            phase_d = PH_IDLE;
          end else if (oc_cur >= limit) begin
            // overflow: drop the rest, tracking escapes
            phase_d = PH_SKIP;
            hc_d    = '0;
            se_d    = (data_byte_i == ChBslash);
          end else if (data_byte_i == ChBslash) begin
            phase_d = PH_ESC;
          end else begin
            bnd  = push(bnd, data_byte_i, ST_BYTE, 1'b0);
            oc_d = oc_cur + COUNT_BITS'(1);
          end
        end
        PH_ESC: begin
          if (data_byte_i == ChU) begin
            phase_d = PH_HEX;
            hc_d    = '0;
            hv_d    = '0;
            hds_d   = '0;
            hs_d    = 1'b0;
          end else begin
            bnd     = push(bnd, unescape(data_byte_i), ST_BYTE, 1'b0);
            oc_d    = oc_cur + COUNT_BITS'(1);
            phase_d = PH_BODY;
          end
        end
        PH_HEX: begin
          if (!hs_cur && hd.ok) begin
            hv_d  = cp;
            hds_d = hds_cur + 3'd1;
          end else begin
            hs_d = 1'b1;
          end
          hc_d = hc_cur + 3'd1;
          if (hc_d == 3'd4) begin
            // fourth byte: emit the code point, or a question mark if there is room
            hc_d    = '0;
            phase_d = PH_BODY;
            if (hds_d == 3'd0 || need > {2'b00, limit}) begin
              if (oc_cur < limit) begin
                bnd  = push(bnd, ChQmark, ST_BYTE, 1'b0);
                oc_d = oc_cur + COUNT_BITS'(1);
              end
            end else begin
              case (cp_len)
                2'd1: bnd = push(bnd, cp[7:0], ST_BYTE, 1'b0);
                2'd2: begin
                  bnd = push(bnd, Utf8Lead2 | {3'b000, cp[10:6]}, ST_BYTE, 1'b0);
                  bnd = push(bnd, Utf8Cont | {2'b00, cp[5:0]}, ST_BYTE, 1'b0);
                end
                default: begin
                  bnd = push(bnd, Utf8Lead3 | {4'b0000, cp[15:12]}, ST_BYTE, 1'b0);
                  bnd = push(bnd, Utf8Cont | {2'b00, cp[11:6]}, ST_BYTE, 1'b0);
                  bnd = push(bnd, Utf8Cont | {2'b00, cp[5:0]}, ST_BYTE, 1'b0);
                end
              endcase
              oc_d = oc_cur + COUNT_BITS'(cp_len);
            end
          end
        end
        PH_SKIP: begin
          if (hc_cur != 3'd0) begin
            hc_d = hc_cur - 3'd1;
          end else if (se_cur) begin
            se_d = 1'b0;
            if (data_byte_i == ChU) hc_d = 3'd4;
          end else if (data_byte_i == ChQuote) begin
            bnd     = push(bnd, 8'h00, ST_TRUNC, 1'b1);
            phase_d = PH_IDLE;
          end else if (data_byte_i == ChBslash) begin
            se_d = 1'b1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  assign res_o = bnd;

  // Advance the decoder state on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hc_q    <= '0;
      hv_q    <= '0;
      hds_q   <= '0;
      hs_q    <= 1'b0;
      oc_q    <= '0;
      se_q    <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      hv_q    <= hv_d;
      hds_q   <= hds_d;
      hs_q    <= hs_d;
      oc_q    <= oc_d;
      se_q    <= se_d;
    end
  end

endmodule

// File: sv/json_string_unescape_top.sv
`timescale 1ns / 1ps
// Top level of the JSON string unescaper: input register, result buffer, config register.
// Depends on jsu_pkg and jsu_core.

// Accepts one byte of JSON text per cycle while in_ready_o is high and returns decoded
// bytes and one status item per string. An accepted transaction is registered, decoded
// in a single pass and its results land in a three-entry result buffer. Most bytes yield
// zero or one result and stream at one per cycle unless the output stalls; a \uXXXX that
// expands to two or three UTF-8 bytes, or an end of data after a pending escape, yields
// up to three results, and then the input side waits while the single output port drains
// them. The input register lets one new byte in while results wait. The user must write
// max_out_bytes through the config channel only while the block is idle; not enforced.
module json_string_unescape_top #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        begin_req_i,
  input  logic        end_of_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import jsu_pkg::*;

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_data_q;
  logic        in_begin_q, in_end_q;
  logic [15:0] max_q;
  bundle_t     bnd_q, bnd_d;
  bundle_t     step_res;
  logic        in_fire, out_fire, bnd_free, advance;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign bnd_free    = (bnd_q.cnt == 2'd0) || (bnd_q.cnt == 2'd1 && out_ready_i);
  assign advance     = in_vld_q && (step_res.cnt == 2'd0 || bnd_free);
  assign in_ready_o  = !in_vld_q || advance;

  jsu_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .data_byte_i    (in_data_q),
    .begin_req_i    (in_begin_q),
    .end_of_data_i  (in_end_q),
    .max_out_bytes_i(max_q),
    .res_o          (step_res)
  );

  // Hold the configured limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 16'd255;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_q <= cfg_data_i;
    end
  end

  // Capture one input transaction
  assign in_vld_d = in_fire ? 1'b1 : (advance ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q  <= data_byte_i;
      in_begin_q <= begin_req_i;
      in_end_q   <= end_of_data_i;
    end
  end

  // Drain the result buffer one entry per transaction, refill from the decoder
  always_comb begin
    bnd_d = bnd_q;
    if (out_fire) begin
      bnd_d.ent[0] = bnd_q.ent[1];
      bnd_d.ent[1] = bnd_q.ent[2];
      bnd_d.cnt    = bnd_q.cnt - 2'd1;
    end
    if (advance && step_res.cnt != 2'd0) bnd_d = step_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_q <= '0;
    end else begin
      bnd_q <= bnd_d;
    end
  end

  assign out_valid_o = (bnd_q.cnt != 2'd0);
  assign out_byte_o  = bnd_q.ent[0].out_byte;
  assign status_o    = bnd_q.ent[0].status;
  assign last_o      = bnd_q.ent[0].last;

endmodule

// File: sv/jsu_chk.sv
`timescale 1ns / 1ps
// Port-level checker for json_string_unescape_top, attached by bind.
// Depends on jsu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jsu_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic [2:0]  status_o,
  input logic        last_o
);
  import jsu_pkg::*;

  logic [11:0] out_pay;

  assign out_pay = {out_byte_o, status_o, last_o};

  // Stalled result holds
  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_pay))
  // Decoded bytes never close a string
  `ASSERT_CLK(a_byte_no_last, out_valid_o && status_o == ST_BYTE |-> !last_o)
  // Status items always close a string
  `ASSERT_CLK(a_status_last, out_valid_o && status_o != ST_BYTE |-> last_o)
  // Status stays within the defined codes
  `ASSERT_NEVER(a_status_range, out_valid_o && status_o > ST_TRUNC)

endmodule

bind json_string_unescape_top jsu_chk u_jsu_chk (.*);
